### rtl/arm_command_safety_gate_core_defines.svh
// Assertion macros for the safety gate checker.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ARM_COMMAND_SAFETY_GATE_CORE_DEFINES_SVH
`define ARM_COMMAND_SAFETY_GATE_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define ACS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define ACS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also watches the reset cycles.
`define ACS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/acs_pkg.sv
// Package for the arm command safety gate: payload structs, stage structs,
// register codes, reason codes and reset values. Depends on nothing.
`default_nettype none

package acs_pkg;

   // Fraction width of the angle format; it only sets the reset limits.
   localparam int unsigned ANGLE_FRAC_BITS = 12;

   localparam int unsigned ANGLE_W   = 16;
   localparam int unsigned TIME_W    = 64;
   localparam int unsigned AGE_CFG_W = 32;
   localparam int unsigned NS_W      = 30;
   localparam int unsigned LHS_W     = ANGLE_W + NS_W;   // |diff| * 1e9
   localparam int unsigned RHS_W     = ANGLE_W + LHS_W;  // max_rate * low age
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;

   localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

   // Reset limits: pi, 2 rad/s and 0.01 rad, rounded and saturated.
   localparam logic [63:0] PI_Q30        = 64'd3373259426;
   localparam logic [63:0] SIGMA_Q30     = 64'd10737418;
   localparam int unsigned ROUND_SHIFT   = 30 - ANGLE_FRAC_BITS;
   localparam logic [63:0] ROUND_HALF    = 64'd1 << (ROUND_SHIFT - 1);
   localparam logic [63:0] PI_SCALED     = (PI_Q30 + ROUND_HALF) >> ROUND_SHIFT;
   localparam logic [63:0] PI_CLAMPED    = (PI_SCALED > 64'd32767) ? 64'd32767 : PI_SCALED;
   localparam logic [63:0] SIGMA_SCALED  = (SIGMA_Q30 + ROUND_HALF) >> ROUND_SHIFT;
   localparam logic [63:0] SIGMA_CLAMPED = (SIGMA_SCALED > 64'd65535) ? 64'd65535 : SIGMA_SCALED;
   localparam logic [63:0] RATE_SCALED   = 64'd2 << ANGLE_FRAC_BITS;
   localparam logic [63:0] RATE_CLAMPED  = (RATE_SCALED > 64'd65535) ? 64'd65535 : RATE_SCALED;

   localparam logic signed [ANGLE_W-1:0] JOINT_MAX_RESET = ANGLE_W'(PI_CLAMPED);
   localparam logic signed [ANGLE_W-1:0] JOINT_MIN_RESET = -JOINT_MAX_RESET;
   localparam logic [ANGLE_W-1:0]        MAX_RATE_RESET  = ANGLE_W'(RATE_CLAMPED);
   localparam logic [ANGLE_W-1:0]        MAX_SIGMA_RESET = ANGLE_W'(SIGMA_CLAMPED);
   localparam logic [AGE_CFG_W-1:0]      MAX_AGE_RESET   = 32'd50000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JOINT_MIN = 3'd0,
      CSR_JOINT_MAX = 3'd1,
      CSR_MAX_RATE  = 3'd2,
      CSR_MAX_SIGMA = 3'd3,
      CSR_MAX_AGE   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      REASON_NONE  = 3'd0,
      REASON_CLOCK = 3'd1,
      REASON_STALE = 3'd2,
      REASON_RANGE = 3'd3,
      REASON_RATE  = 3'd4,
      REASON_SIGMA = 3'd5
   } reason_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] joint_pos;
      logic signed [ANGLE_W-1:0] joint_target;
      logic [ANGLE_W-1:0]        joint_sigma;
      logic [TIME_W-1:0]         state_time_ns;
      logic [TIME_W-1:0]         now_time_ns;
      logic                      last_joint;
   } req_type;

   typedef struct packed {
      logic       approve;
      reason_type reason;
   } rsp_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] joint_min;
      logic signed [ANGLE_W-1:0] joint_max;
      logic [ANGLE_W-1:0]        max_rate;
      logic [ANGLE_W-1:0]        max_sigma;
      logic [AGE_CFG_W-1:0]      max_age_ns;
   } cfg_type;

   // After the age subtract and the per-joint compares.
   typedef struct packed {
      logic [TIME_W-1:0]  age;
      logic               clock_behind;
      logic [ANGLE_W-1:0] mag;
      logic               range_fail;
      logic               sigma_fail;
      logic               last;
   } front_type;

   // After the two rate products.
   typedef struct packed {
      logic [LHS_W-1:0] lhs;
      logic [RHS_W-1:0] rhs;
      logic             rate_exempt;
      logic             clock_behind;
      logic             stale;
      logic             zero_age;
      logic             range_fail;
      logic             sigma_fail;
      logic             last;
   } rate_type;

endpackage

`default_nettype wire

### rtl/arm_command_safety_gate_core.sv
// A joint passes the four pipeline registers (input, age/compare, rate product,
//    result if last) in turn; the last joint's verdict appears in rsp_valid.
//    Throughput: one joint per cycle unless a stalled verdict holds back a last
//    joint; each register holds one item and moves when the next stage is free.
// Reset (synchronous, active high) empties the pipeline, clears the sticky flags
//    and loads the limit registers with their reset values.
`default_nettype none

module arm_command_safety_gate_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // joint transactions in
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  acs_pkg::req_type                   req_data,
   // verdict transactions out
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output acs_pkg::rsp_type                   rsp_data,
   // limit register writes
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [acs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [acs_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import acs_pkg::*;

   cfg_type   cfg;
   logic      front_valid;
   logic      front_ready;
   front_type front_data;
   logic      rate_valid;
   logic      rate_ready;
   rate_type  rate_data;

   // Limits are to be written by the user only while the pipeline is empty; the
   // block itself leaves this unchecked, so every stage may read them directly.
   acs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Register the joint, then take the age (its borrow flags now behind the
   // state time), the step size and the range and uncertainty compares.
   acs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .front_valid (front_valid),
      .front_ready (front_ready),
      .front_data  (front_data)
   );

   // Form both sides of the rate test as products, so no division is needed.
   acs_rate u_rate (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .front_valid (front_valid),
      .front_ready (front_ready),
      .front_data  (front_data),
      .rate_valid  (rate_valid),
      .rate_ready  (rate_ready),
      .rate_data   (rate_data)
   );

   // Fold each joint into the sticky flags; on the last joint, pick the reason
   // by priority and hold it in the result register until taken. Joints that
   // are not last drain even while a verdict waits.
   acs_verdict u_verdict (
      .clock      (clock),
      .reset      (reset),
      .rate_valid (rate_valid),
      .rate_ready (rate_ready),
      .rate_data  (rate_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/acs_csr.sv
// Configuration registers of the safety gate.
// Depends on acs_pkg.
`default_nettype none

module acs_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [acs_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [acs_pkg::CSR_DAT_W-1:0] csr_wdata,
   output acs_pkg::cfg_type                  cfg
);
   import acs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_JOINT_MIN: cfg_in.joint_min  = csr_wdata[ANGLE_W-1:0];
            CSR_JOINT_MAX: cfg_in.joint_max  = csr_wdata[ANGLE_W-1:0];
            CSR_MAX_RATE:  cfg_in.max_rate   = csr_wdata[ANGLE_W-1:0];
            CSR_MAX_SIGMA: cfg_in.max_sigma  = csr_wdata[ANGLE_W-1:0];
            CSR_MAX_AGE:   cfg_in.max_age_ns = csr_wdata[AGE_CFG_W-1:0];
            default:       cfg_in = cfg_ff;  // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.joint_min  <= JOINT_MIN_RESET;
         cfg_ff.joint_max  <= JOINT_MAX_RESET;
         cfg_ff.max_rate   <= MAX_RATE_RESET;
         cfg_ff.max_sigma  <= MAX_SIGMA_RESET;
         cfg_ff.max_age_ns <= MAX_AGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/acs_front.sv
// Input register and first stage: state age, joint step size, range and
// uncertainty compares. Depends on acs_pkg.
`default_nettype none

module acs_front (
   input  wire logic        clock,
   input  wire logic        reset,
   input  acs_pkg::cfg_type cfg,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  acs_pkg::req_type req_data,
   output logic             front_valid,
   input  wire logic        front_ready,
   output acs_pkg::front_type front_data
);
   import acs_pkg::*;

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_ff;
   logic      front_valid_ff;
   logic      front_valid_in;
   front_type front_ff;
   front_type front_in;

   logic                    s2_ready;
   logic                    s1_ready;
   logic                    s1_move;
   logic [TIME_W:0]         age_wide;
   logic signed [ANGLE_W:0] diff;
   logic [ANGLE_W:0]        diff_abs;

   assign s2_ready  = !front_valid_ff || front_ready;
   assign s1_move   = in_valid_ff && s2_ready;
   assign s1_ready  = !in_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign front_valid = front_valid_ff;
   assign front_data  = front_ff;

   always_comb begin
      age_wide = {1'b0, in_ff.now_time_ns} - {1'b0, in_ff.state_time_ns};
      diff     = {in_ff.joint_target[ANGLE_W-1], in_ff.joint_target}
               - {in_ff.joint_pos[ANGLE_W-1], in_ff.joint_pos};
      diff_abs = diff[ANGLE_W] ? (ANGLE_W+1)'(-diff) : diff;

      front_in.age          = age_wide[TIME_W-1:0];
      front_in.clock_behind = age_wide[TIME_W];   // borrow: now before state time
      front_in.mag          = diff_abs[ANGLE_W-1:0];
      front_in.range_fail   = (in_ff.joint_target < cfg.joint_min)
                           || (in_ff.joint_target > cfg.joint_max);
      front_in.sigma_fail   = in_ff.joint_sigma > cfg.max_sigma;
      front_in.last         = in_ff.last_joint;

      in_valid_in    = (req_valid && s1_ready) || (in_valid_ff && !s2_ready);
      front_valid_in = s1_move || (front_valid_ff && !front_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         front_valid_ff <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         in_ff <= req_data;
      end
      if (s1_move) begin
         front_ff <= front_in;
      end
   end

endmodule

`default_nettype wire

### rtl/acs_rate.sv
// Second stage: rate products |diff|*1e9 and max_rate*age, stale and zero
// age tests. Depends on acs_pkg.
`default_nettype none

module acs_rate (
   input  wire logic          clock,
   input  wire logic          reset,
   input  acs_pkg::cfg_type   cfg,
   input  wire logic          front_valid,
   output logic               front_ready,
   input  acs_pkg::front_type front_data,
   output logic               rate_valid,
   input  wire logic          rate_ready,
   output acs_pkg::rate_type  rate_data
);
   import acs_pkg::*;

   logic     rate_valid_ff;
   logic     rate_valid_in;
   rate_type rate_ff;
   rate_type rate_in;
   logic     move;

   assign front_ready = !rate_valid_ff || rate_ready;
   assign move        = front_valid && front_ready;
   assign rate_valid  = rate_valid_ff;
   assign rate_data   = rate_ff;

   always_comb begin
      // An age at or above 2^LHS_W with a nonzero rate always passes, so
      // only the low age bits enter the product.
      rate_in.lhs          = LHS_W'(front_data.mag) * LHS_W'(NS_PER_S);
      rate_in.rhs          = RHS_W'(cfg.max_rate) * RHS_W'(front_data.age[LHS_W-1:0]);
      rate_in.rate_exempt  = (|front_data.age[TIME_W-1:LHS_W]) && (|cfg.max_rate);
      rate_in.clock_behind = front_data.clock_behind;
      rate_in.stale        = front_data.age > TIME_W'(cfg.max_age_ns);
      rate_in.zero_age     = front_data.age == '0;
      rate_in.range_fail   = front_data.range_fail;
      rate_in.sigma_fail   = front_data.sigma_fail;
      rate_in.last         = front_data.last;

      rate_valid_in = move || (rate_valid_ff && !rate_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_valid_ff <= 1'b0;
      end else begin
         rate_valid_ff <= rate_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rate_ff <= rate_in;
      end
   end

endmodule

`default_nettype wire

### rtl/acs_verdict.sv
// Final stage: rate compare, sticky failure flags, verdict priority and the
// result register. Depends on acs_pkg.
`default_nettype none

module acs_verdict (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rate_valid,
   output logic              rate_ready,
   input  acs_pkg::rate_type rate_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output acs_pkg::rsp_type  rsp_data
);
   import acs_pkg::*;

   logic    range_failed_ff;
   logic    range_failed_in;
   logic    rate_failed_ff;
   logic    rate_failed_in;
   logic    sigma_failed_ff;
   logic    sigma_failed_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic out_free;
   logic take;
   logic rate_fail;
   logic any_range;
   logic any_rate;
   logic any_sigma;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rate_ready = !rate_data.last || out_free;
   assign take       = rate_valid && rate_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      rate_fail = !rate_data.rate_exempt && (RHS_W'(rate_data.lhs) > rate_data.rhs);
      any_range = range_failed_ff || rate_data.range_fail;
      any_rate  = rate_failed_ff  || rate_fail;
      any_sigma = sigma_failed_ff || rate_data.sigma_fail;

      if (rate_data.clock_behind) begin
         rsp_in.reason = REASON_CLOCK;
      end else if (rate_data.stale) begin
         rsp_in.reason = REASON_STALE;
      end else if (any_range) begin
         rsp_in.reason = REASON_RANGE;
      end else if (rate_data.zero_age) begin
         rsp_in.reason = REASON_CLOCK;
      end else if (any_rate) begin
         rsp_in.reason = REASON_RATE;
      end else if (any_sigma) begin
         rsp_in.reason = REASON_SIGMA;
      end else begin
         rsp_in.reason = REASON_NONE;
      end
      rsp_in.approve = rsp_in.reason == REASON_NONE;

      range_failed_in = range_failed_ff;
      rate_failed_in  = rate_failed_ff;
      sigma_failed_in = sigma_failed_ff;
      if (take) begin
         // Clear on the last joint; otherwise accumulate.
         range_failed_in = !rate_data.last && any_range;
         rate_failed_in  = !rate_data.last && any_rate;
         sigma_failed_in = !rate_data.last && any_sigma;
      end

      rsp_valid_in = (rsp_valid_ff && rsp_stall) || (take && rate_data.last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_failed_ff <= 1'b0;
         rate_failed_ff  <= 1'b0;
         sigma_failed_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         range_failed_ff <= range_failed_in;
         rate_failed_ff  <= rate_failed_in;
         sigma_failed_ff <= sigma_failed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && rate_data.last) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

### rtl/acs_checker.sv
// Port-level checker for the safety gate, bound to the top level.
// Depends on acs_pkg and arm_command_safety_gate_core_defines.svh.
`default_nettype none

`include "arm_command_safety_gate_core_defines.svh"

module acs_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_stall,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_stall,
   input  acs_pkg::rsp_type rsp_data
);
   import acs_pkg::*;

   // Reset empties the result register.
   `ACS_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid, "rsp_valid after reset")

   // With no verdict waiting, every stage drains, so the input never stalls.
   `ACS_ASSERT_NOW(a_no_stall_when_out_empty, clock, reset, !rsp_valid, !req_stall, "req_stall with empty output")

   // A stalled verdict stays.
   `ACS_ASSERT_NEXT(a_rsp_holds_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped under stall")

   // A stalled verdict keeps its payload.
   `ACS_ASSERT_NEXT(a_rsp_holds_data, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "rsp_data changed under stall")

endmodule

bind arm_command_safety_gate_core acs_checker u_acs_checker (.*);

`default_nettype wire

### bench/tb_arm_command_safety_gate_core.sv
// Self-checking bench for arm_command_safety_gate_core: directed and random joint
// commands against a built-in verdict predictor, random input idles and output stalls.
// Depends on acs_pkg and the arm_command_safety_gate_core RTL.
`default_nettype none

module tb_arm_command_safety_gate_core;
   timeunit 1ns;
   timeprecision 1ps;

   import acs_pkg::*;

   // Half of the 20 ns clock period.
   localparam int          HALF_PERIOD     = 10;
   // Give up after this many cycles with no transaction on any channel.
   localparam int          STALL_LIMIT     = 2000;
   // Cycles to let the pipeline empty of non-last joints before a limit write.
   localparam int          DRAIN_CYCLES    = 8;
   // Index past the last limit register; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam logic [63:0] NS_PER_SECOND   = 64'd1000000000;
   localparam logic [63:0] EPOCH_NS        = 64'd1000000000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   arm_command_safety_gate_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Verdict predictor: its own copy of the limit registers and the three
   // sticky failure flags of the command being assembled.
   // ------------------------------------------------------------------
   cfg_type     limits = '{JOINT_MIN_RESET, JOINT_MAX_RESET, MAX_RATE_RESET,
                           MAX_SIGMA_RESET, MAX_AGE_RESET};
   logic        range_seen = 1'b0;
   logic        rate_seen  = 1'b0;
   logic        sigma_seen = 1'b0;
   rsp_type     verdicts_due[$];
   req_type     pending_joints[$];

   int          mismatches     = 0;
   int          joints_judged  = 0;
   int          verdicts_total = 0;
   int          settings_used  = 1;
   int          reason_tally[6] = '{default: 0};

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   function automatic void apply_limit(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_DAT_W-1:0] value);
      case (idx)
         CSR_JOINT_MIN: limits.joint_min  = value[ANGLE_W-1:0];
         CSR_JOINT_MAX: limits.joint_max  = value[ANGLE_W-1:0];
         CSR_MAX_RATE:  limits.max_rate   = value[ANGLE_W-1:0];
         CSR_MAX_SIGMA: limits.max_sigma  = value[ANGLE_W-1:0];
         CSR_MAX_AGE:   limits.max_age_ns = value[AGE_CFG_W-1:0];
         default: ;
      endcase
   endfunction

   // Fold one accepted joint into the flags; on the last joint queue the verdict.
   function automatic void judge_joint(input req_type j);
      logic [63:0]        age;
      logic signed [16:0] diff;
      logic [16:0]        mag;
      logic [79:0]        demand;
      logic [79:0]        allowance;
      reason_type         why;
      rsp_type            verdict;
      age  = j.now_time_ns - j.state_time_ns;
      diff = {j.joint_target[ANGLE_W-1], j.joint_target} - {j.joint_pos[ANGLE_W-1], j.joint_pos};
      mag  = diff[16] ? -diff : diff;
      // Exact products: an allowance past 64 bits always covers the demand.
      demand    = 80'(mag) * 80'(NS_PER_SECOND);
      allowance = 80'(limits.max_rate) * 80'(age);
      joints_judged++;
      if ($signed(j.joint_target) < $signed(limits.joint_min) ||
          $signed(j.joint_target) > $signed(limits.joint_max)) begin
         range_seen = 1'b1;
      end
      if (j.joint_sigma > limits.max_sigma) begin
         sigma_seen = 1'b1;
      end
      if (demand > allowance) begin
         rate_seen = 1'b1;
      end
      if (!j.last_joint) begin
         return;
      end
      // Priority: clock behind, stale, range, zero age, rate, uncertainty.
      if (j.now_time_ns < j.state_time_ns) begin
         why = REASON_CLOCK;
      end else if (age > 64'(limits.max_age_ns)) begin
         why = REASON_STALE;
      end else if (range_seen) begin
         why = REASON_RANGE;
      end else if (age == 64'd0) begin
         why = REASON_CLOCK;
      end else if (rate_seen) begin
         why = REASON_RATE;
      end else if (sigma_seen) begin
         why = REASON_SIGMA;
      end else begin
         why = REASON_NONE;
      end
      verdict.approve = (why == REASON_NONE);
      verdict.reason  = why;
      verdicts_due.push_back(verdict);
      verdicts_total++;
      reason_tally[int'(why)]++;
      range_seen = 1'b0;
      rate_seen  = 1'b0;
      sigma_seen = 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge, predict on every
   // accepted joint, check every accepted verdict, and run the watchdog.
   // ------------------------------------------------------------------
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int   quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         rsp_taken    <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) begin
            judge_joint(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("verdict approve=%0d reason=%0d with none outstanding",
                                         rsp_data.approve, rsp_data.reason));
            end else begin
               automatic rsp_type want = verdicts_due.pop_front();
               if (rsp_data.approve !== want.approve) begin
                  report_mismatch($sformatf("approve %0d, predicted %0d",
                                            rsp_data.approve, want.approve));
               end
               if (rsp_data.reason !== want.reason) begin
                  report_mismatch($sformatf("reason %0d, predicted %0d",
                                            rsp_data.reason, want.reason));
               end
            end
         end
         // Count cycles in which no channel moves a transaction.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d verdicts outstanding",
                     STALL_LIMIT, verdicts_due.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Joint driver: change at the falling edge, hold the payload until it is
   // taken, then wait a random gap. Every 64th joint, hold off until every
   // outstanding verdict has come back.
   // ------------------------------------------------------------------
   int unsigned send_gap      = 0;
   bit          send_burst    = 1'b0;
   bit          drain_hold    = 1'b0;
   int          joints_issued = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (drain_hold && verdicts_due.size() != 0) begin
            req_valid <= 1'b0;
         end else if (pending_joints.size() != 0) begin
            drain_hold = 1'b0;
            req_data  <= pending_joints.pop_front();
            req_valid <= 1'b1;
            joints_issued++;
            if (joints_issued % 64 == 0) begin
               drain_hold = 1'b1;
            end
            // Flip between gap-free stretches and idling stretches now and then.
            if ($urandom_range(0, 19) == 0) begin
               send_burst = !send_burst;
            end
            send_gap = send_burst ? 0 : $urandom_range(0, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Verdict receiver: after each taken verdict stall for a random count,
   // and throw in an occasional stall while nothing is arriving.
   // ------------------------------------------------------------------
   int unsigned stall_left = 0;
   bit          take_burst = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 19) == 0) begin
               take_burst = !take_burst;
            end
            stall_left = take_burst ? 0 : $urandom_range(0, 10);
         end else if (stall_left == 0 && !take_burst && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 10);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) begin
            stall_left--;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_joint(input int pos, input int target, input int sigma,
                             input logic [63:0] t_state, input logic [63:0] t_now,
                             input bit last);
      req_type j;
      j.joint_pos     = 16'(pos);
      j.joint_target  = 16'(target);
      j.joint_sigma   = 16'(sigma);
      j.state_time_ns = t_state;
      j.now_time_ns   = t_now;
      j.last_joint    = last;
      pending_joints.push_back(j);
   endtask

   function automatic int random_angle();
      logic signed [ANGLE_W-1:0] a;
      a = 16'($urandom);
      return a;
   endfunction

   // Pick a target inside the window, often on an edge; a random angle if it is empty.
   function automatic int pick_in_window(input int lo, input int hi);
      int unsigned choice;
      if (lo > hi) begin
         return random_angle();
      end
      choice = $urandom_range(0, 3);
      if (choice == 0) begin
         return lo;
      end else if (choice == 1) begin
         return hi;
      end
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Wait until every joint is taken, every verdict is back, and the
   // pipeline has had time to retire trailing non-last joints.
   task automatic settle();
      do begin
         @(posedge clock);
      end while (pending_joints.size() != 0 || req_valid || verdicts_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Present one register write and hold it until the block takes it.
   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      apply_limit(idx, value);
   endtask

   task automatic program_limits(input int lo, input int hi, input int rate,
                                 input int sigma, input logic [31:0] age);
      write_limit(CSR_JOINT_MIN, 32'(lo));
      write_limit(CSR_JOINT_MAX, 32'(hi));
      write_limit(CSR_MAX_RATE, 32'(rate));
      write_limit(CSR_MAX_SIGMA, 32'(sigma));
      write_limit(CSR_MAX_AGE, age);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // One command of one to six joints. Most are well formed against the
   // current limits with a sprinkling of single violations; the rest have
   // the clock behind, stale or zero age, times that differ per joint, or
   // entirely random fields.
   task automatic queue_random_command(inout int added);
      int unsigned scenario;
      int unsigned joints;
      int unsigned age_cap;
      logic [63:0] t_state;
      logic [63:0] t_now;
      logic [63:0] age;
      logic [63:0] room;
      int          target;
      int          pos;
      int          mag;
      int          sigma;
      bit          last;
      scenario = $urandom_range(0, 99);
      joints   = $urandom_range(1, 6);
      t_state  = {1'b0, 31'($urandom), 32'($urandom)} | 64'h1_0000_0000;
      if (scenario < 60) begin
         if (limits.max_age_ns == 0) begin
            age = 64'd0;
         end else begin
            age_cap = (limits.max_age_ns < 32'd2000000 || $urandom_range(0, 1) == 0) ?
                      limits.max_age_ns : 32'd2000000;
            age = $urandom_range(1, age_cap);
         end
         t_now = t_state + age;
      end else if (scenario < 68) begin
         t_now = t_state - 64'd1 - $urandom_range(0, 1000000);
      end else if (scenario < 76) begin
         t_now = t_state + 64'(limits.max_age_ns) + 64'd1 + $urandom_range(0, 1000000);
      end else begin
         t_now = t_state;
      end
      age  = t_now - t_state;
      room = (age > 64'hFFFF_FFFF) ? 64'd65535 : (64'(limits.max_rate) * age) / NS_PER_SECOND;
      if (room > 64'd65535) begin
         room = 64'd65535;
      end
      for (int k = 0; k < joints; k++) begin
         last = (k == joints - 1);
         if (scenario >= 90) begin
            // Noise: every field random, command boundaries included.
            push_joint(random_angle(), random_angle(), $urandom_range(0, 65535),
                       {$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 1));
            continue;
         end
         if ($urandom_range(0, 11) == 0) begin
            target = $urandom_range(0, 1) ? $signed(limits.joint_max) + 1
                                          : $signed(limits.joint_min) - 1;
            if (target > 32767 || target < -32768) begin
               target = random_angle();
            end
         end else begin
            target = pick_in_window($signed(limits.joint_min), $signed(limits.joint_max));
         end
         if ($urandom_range(0, 7) == 0 && room < 64'd65535) begin
            mag = int'(room) + 1 + int'($urandom_range(0, 2));
         end else if ($urandom_range(0, 2) == 0) begin
            mag = int'(room);
         end else begin
            mag = $urandom_range(0, 32'(room));
         end
         if (mag > 65535) begin
            mag = 65535;
         end
         pos = $urandom_range(0, 1) ? target + mag : target - mag;
         if (pos > 32767 || pos < -32768) begin
            pos = (target >= 0) ? target - mag : target + mag;
         end
         if (pos > 32767) begin
            pos = 32767;
         end else if (pos < -32768) begin
            pos = -32768;
         end
         if ($urandom_range(0, 9) == 0 && limits.max_sigma < 16'hFFFF) begin
            sigma = $urandom_range(int'(limits.max_sigma) + 1, 65535);
         end else begin
            sigma = $urandom_range(0, limits.max_sigma);
         end
         if (scenario >= 82 && !last) begin
            // Each joint carries its own times; only the last one's decide clock and age faults.
            push_joint(pos, target, sigma, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
         end else begin
            push_joint(pos, target, sigma, t_state, t_now, last);
         end
      end
      added += joints;
   endtask

   task automatic random_phase(input int joints_wanted);
      int added;
      added = 0;
      while (added < joints_wanted) begin
         queue_random_command(added);
      end
      settle();
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed joints against the reset limits:
      // window +/-12868, rate 8192, sigma 41, age 50 ms.
      push_joint(0, 0, 0, EPOCH_NS, EPOCH_NS + 1000, 1);            // clean single joint
      push_joint(100, 104, 41, EPOCH_NS, EPOCH_NS + 1000000, 0);     // three clean joints,
      push_joint(-200, -192, 0, EPOCH_NS, EPOCH_NS + 1000000, 0);    // one right on the
      push_joint(5, 5, 10, EPOCH_NS, EPOCH_NS + 1000000, 1);         // rate edge
      push_joint(0, 0, 0, EPOCH_NS + 5, EPOCH_NS, 1);                // clock behind
      push_joint(0, 0, 0, EPOCH_NS, EPOCH_NS + 50000000, 1);         // age exactly at limit
      push_joint(0, 0, 0, EPOCH_NS, EPOCH_NS + 50000001, 1);         // one past: stale
      push_joint(12868, 12868, 0, EPOCH_NS, EPOCH_NS + 1000, 0);     // both window edges
      push_joint(-12868, -12868, 0, EPOCH_NS, EPOCH_NS + 1000, 1);
      push_joint(12869, 12869, 0, EPOCH_NS, EPOCH_NS + 1000, 1);     // just above window
      push_joint(-12869, -12869, 0, EPOCH_NS, EPOCH_NS + 1000, 1);   // just below window
      push_joint(0, 0, 0, EPOCH_NS, EPOCH_NS, 1);                    // zero age
      push_joint(0, 8, 0, EPOCH_NS, EPOCH_NS + 1000000, 1);          // rate: 8 allowed
      push_joint(0, -9, 0, EPOCH_NS, EPOCH_NS + 1000000, 1);         // rate: 9 too fast
      push_joint(0, 0, 41, EPOCH_NS, EPOCH_NS + 1000, 1);            // sigma at limit
      push_joint(0, 0, 42, EPOCH_NS, EPOCH_NS + 1000, 1);            // sigma over
      push_joint(20000, 20000, 0, EPOCH_NS, EPOCH_NS + 1000, 0);     // clock beats range
      push_joint(0, 0, 0, EPOCH_NS + 1, EPOCH_NS, 1);
      push_joint(20000, 20000, 0, EPOCH_NS, EPOCH_NS + 60000000, 1); // stale beats range
      push_joint(20000, 20000, 0, EPOCH_NS, EPOCH_NS, 1);            // range beats zero age
      push_joint(0, 100, 0, EPOCH_NS, EPOCH_NS, 1);                  // zero age beats rate
      push_joint(0, 100, 500, EPOCH_NS, EPOCH_NS + 1000, 1);         // rate beats sigma
      // Huge age on a non-last joint: the allowance overflows 64 bits and passes.
      push_joint(-32768, 12868, 0, 64'd0, '1, 0);
      push_joint(0, 0, 0, EPOCH_NS, EPOCH_NS + 1000, 1);
      push_joint(-32768, 32767, 65535, '1, '1, 1);                   // largest step, sigma and times at their top
      push_joint(32767, -32768, 0, 64'd0, '1, 1);                    // largest age: stale
      settle();

      // Typical random limits, plus a write to an unused index that must do nothing.
      write_limit(CSR_SPARE_INDEX, $urandom);
      program_limits(-int'($urandom_range(2000, 20000)), $urandom_range(2000, 20000),
                     $urandom_range(100, 30000), $urandom_range(10, 2000),
                     $urandom_range(100000, 1000000000));
      random_phase(90);

      // Tightest age, rate and sigma limits, full window: nothing but a zero age is fresh, no motion, no sigma.
      program_limits(-32768, 32767, 0, 0, 32'd0);
      random_phase(30);

      // Loosest limits.
      program_limits(-32768, 32767, 65535, 65535, 32'hFFFF_FFFF);
      random_phase(60);

      // Inverted window: every target is out of range.
      program_limits(100, -100, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(1000, 100000000));
      random_phase(30);

      program_limits(-int'($urandom_range(0, 32768)), $urandom_range(0, 32767),
                     $urandom_range(1, 65535), $urandom_range(0, 65535), $urandom);
      random_phase(90);

      // Back to the power-up limits, written explicitly this time.
      program_limits(JOINT_MIN_RESET, JOINT_MAX_RESET, MAX_RATE_RESET, MAX_SIGMA_RESET,
                     MAX_AGE_RESET);
      random_phase(90);

      if (verdicts_due.size() != 0) begin
         report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
      end
      $display("covered %0d joints and %0d verdicts over %0d limit settings",
               joints_judged, verdicts_total, settings_used);
      $display("verdicts: approve %0d, clock %0d, stale %0d, range %0d, rate %0d, sigma %0d",
               reason_tally[REASON_NONE], reason_tally[REASON_CLOCK], reason_tally[REASON_STALE],
               reason_tally[REASON_RANGE], reason_tally[REASON_RATE], reason_tally[REASON_SIGMA]);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
